// ===== rtl/rism_pkg.sv =====
// Shared types and constants for the RPN integer stack machine.
`timescale 1ns / 1ps
`default_nettype none
package rism_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_BADOP = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_CHOICE = 4'd4,
    OP_ASSIGN = 4'd5,
    OP_NEG    = 4'd6,
    OP_NOT    = 4'd7,
    OP_AND    = 4'd8,
    OP_OR     = 4'd9,
    OP_POW    = 4'd10
  } opcode_t;

  localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_T,
    S_RD_S,
    S_RD_D,
    S_CAP_D,
    S_WAIT,
    S_EXEC,
    S_ITER,
    S_WRITE,
    S_RD_TOP,
    S_TOP,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load_in;    // capture input item
    logic       rd_req;     // issue a RAM read
    logic [1:0] rd_sel;     // 0 top, 1 second, 2 deepest
    logic       cap_t;      // capture read data into operand registers
    logic       cap_s;
    logic       cap_d;
    logic       start;      // start operation
    logic       step;       // one iteration of div or pow
    logic       write;      // write result or push
    logic       cap_top;    // capture top of stack for the report
    logic       out_load;   // load result register
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic     is_push;
    logic     bad_op;
    logic     under;
    logic     over;
    logic     iterative;
    logic     iter_done;
    logic     empty;
    logic [1:0] arity;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rism_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rism_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/rism_datapath.sv =====
// Datapath: stack pointer, operand registers, ALU, iterative divider and power unit.
`timescale 1ns / 1ps
`default_nettype none
module rism_datapath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rism_pkg::ctrl_t      ctrl,
  output rism_pkg::stat_t           stat,
  input  wire logic                 req_type,
  input  wire logic signed [31:0]   number,
  input  wire logic [3:0]           opcode,
  input  wire logic                 fresh_start,
  output logic signed [31:0]        top_value,
  output logic                      top_valid,
  output logic [6:0]                depth,
  output logic [1:0]                status
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  logic [DW-1:0] sp;
  logic [DW-1:0] sp_next;
  logic [DW-1:0] dep_in;
  logic          push_r;
  logic [31:0]   num_r;
  logic [3:0]    op_r;
  logic [1:0]    st_r;
  logic          decide;
  logic [31:0]   t_r, s_r, d_r, res_r, top_r;
  logic [1:0]    arity;
  logic          bad;

  // Iterative unit state
  logic [31:0]   quo, rem, dvs, acc, sq, ex;
  logic [5:0]    cnt;
  logic          neg_q;
  logic          pow_mul_ph;  // 0: acc*=sq phase, 1: sq*=sq phase

  // RAM
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  rism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    unique case (op_r)
      rism_pkg::OP_CHOICE: arity = 2'd3;
      rism_pkg::OP_ASSIGN, rism_pkg::OP_NEG, rism_pkg::OP_NOT: arity = 2'd1;
      default: arity = 2'd2;
    endcase
  end
  assign bad = op_r > rism_pkg::OP_POW;

  assign stat.is_push   = push_r;
  assign stat.bad_op    = bad;
  assign stat.under     = sp < DW'(arity);
  assign stat.over      = sp == FULL;
  assign stat.iterative = (op_r == rism_pkg::OP_DIV && t_r != 32'd0 && !push_r) ||
                          (op_r == rism_pkg::OP_POW && !t_r[31] && !push_r);
  assign stat.iter_done = cnt == 6'd0;
  assign stat.empty     = sp == '0;
  assign stat.arity     = arity;

  assign dep_in = fresh_start ? '0 : sp;

  always_comb begin
    logic [DW-1:0] off;
    off = DW'(ctrl.rd_sel) + DW'(1);
    addr = AW'(sp - off);
    we    = 1'b0;
    wdata = res_r;
    if (ctrl.write) begin
      we = 1'b1;
      if (push_r) begin
        addr  = AW'(sp);
        wdata = num_r;
      end else begin
        addr = AW'(sp - DW'(arity));
      end
    end
  end

  always_comb begin
    sp_next = sp;
    if (ctrl.load_in) sp_next = dep_in;
    else if (ctrl.write) sp_next = push_r ? sp + DW'(1) : sp - DW'(arity) + DW'(1);
  end

  // Restoring division step on magnitudes.
  logic [32:0] trial;
  logic [31:0] rem_sh;
  assign rem_sh = {rem[30:0], quo[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
    if (ctrl.load_in) begin
      push_r <= ~req_type;
      num_r  <= number;
      op_r   <= opcode;
    end
    if (ctrl.cap_t) t_r <= rdata;
    if (ctrl.cap_s) s_r <= rdata;
    if (ctrl.cap_d) d_r <= rdata;
    if (ctrl.cap_top) top_r <= rdata;
    if (ctrl.start) begin
      cnt        <= 6'd32;
      pow_mul_ph <= 1'b0;
      unique case (op_r)
        rism_pkg::OP_ADD: res_r <= s_r + t_r;
        rism_pkg::OP_SUB: res_r <= s_r - t_r;
        rism_pkg::OP_MUL: res_r <= s_r * t_r;
        rism_pkg::OP_DIV: res_r <= s_r[31] ? (32'd0 - rism_pkg::INT_MAX) : rism_pkg::INT_MAX;
        rism_pkg::OP_CHOICE: res_r <= (d_r != 32'd0) ? s_r : t_r;
        rism_pkg::OP_ASSIGN: res_r <= t_r;
        rism_pkg::OP_NEG: res_r <= 32'd0 - t_r;
        rism_pkg::OP_NOT: res_r <= ~t_r;
        rism_pkg::OP_AND: res_r <= s_r & t_r;
        rism_pkg::OP_OR: res_r <= s_r | t_r;
        default: begin
          if (s_r == 32'd1) res_r <= 32'd1;
          else if (s_r == 32'hFFFF_FFFF) res_r <= t_r[0] ? 32'hFFFF_FFFF : 32'd1;
          else res_r <= 32'd0;
        end
      endcase
      quo   <= s_r[31] ? 32'd0 - s_r : s_r;
      dvs   <= t_r[31] ? 32'd0 - t_r : t_r;
      rem   <= 32'd0;
      neg_q <= s_r[31] ^ t_r[31];
      acc   <= 32'd1;
      sq    <= s_r;
      ex    <= t_r;
    end else if (ctrl.step) begin
      if (op_r == rism_pkg::OP_DIV) begin
        cnt <= cnt - 6'd1;
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        if (cnt == 6'd1) begin
          res_r <= neg_q ? 32'd0 - (trial[32] ? {quo[30:0], 1'b0} : {quo[30:0], 1'b1})
                         : (trial[32] ? {quo[30:0], 1'b0} : {quo[30:0], 1'b1});
        end
      end else begin
        // Alternate multiply phases so one multiplier sits between registers.
        pow_mul_ph <= ~pow_mul_ph;
        if (!pow_mul_ph) begin
          if (ex[0]) acc <= acc * sq;
        end else begin
          sq  <= sq * sq;
          ex  <= ex >> 1;
          cnt <= (ex[31:1] == 31'd0) ? 6'd0 : cnt;
        end
        res_r <= acc;
      end
    end
    if (ctrl.out_load) begin
      top_value <= (sp != '0) ? top_r : 32'd0;
      top_valid <= sp != '0;
      depth     <= 7'(sp);
      status    <= st_r;
    end
  end

  // Decide the status the cycle after the item is taken, once a fresh start
  // has settled the stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      decide <= 1'b0;
    end else begin
      decide <= ctrl.load_in;
    end
    if (ctrl.load_in) begin
      st_r <= rism_pkg::ST_OK;
    end else if (decide) begin
      if (push_r) st_r <= stat.over ? rism_pkg::ST_OVER : rism_pkg::ST_OK;
      else if (bad) st_r <= rism_pkg::ST_BADOP;
      else if (stat.under) st_r <= rism_pkg::ST_UNDER;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rism_ctrl.sv =====
// Controller state machine sequencing stack reads, execution and write-back.
`timescale 1ns / 1ps
`default_nettype none
module rism_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire rism_pkg::stat_t stat,
  output rism_pkg::ctrl_t      ctrl
);
  rism_pkg::state_t state, state_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      rism_pkg::S_IDLE:   if (in_valid && !in_stall) state_next = rism_pkg::S_WAIT;
      rism_pkg::S_WAIT: begin
        if (stat.is_push) state_next = stat.over ? rism_pkg::S_RD_TOP : rism_pkg::S_WRITE;
        else if (stat.bad_op || stat.under) state_next = rism_pkg::S_RD_TOP;
        else state_next = rism_pkg::S_RD_T;
      end
      rism_pkg::S_RD_T:   state_next = rism_pkg::S_RD_S;
      rism_pkg::S_RD_S:   state_next = rism_pkg::S_RD_D;
      rism_pkg::S_RD_D:   state_next = rism_pkg::S_CAP_D;
      rism_pkg::S_CAP_D:  state_next = rism_pkg::S_EXEC;
      rism_pkg::S_EXEC:   state_next = stat.iterative ? rism_pkg::S_ITER : rism_pkg::S_WRITE;
      rism_pkg::S_ITER:   if (stat.iter_done) state_next = rism_pkg::S_WRITE;
      rism_pkg::S_WRITE:  state_next = rism_pkg::S_RD_TOP;
      rism_pkg::S_RD_TOP: state_next = rism_pkg::S_TOP;
      rism_pkg::S_TOP:    state_next = rism_pkg::S_OUT;
      rism_pkg::S_OUT:    state_next = rism_pkg::S_IDLE;
      default:            state_next = rism_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_stall = 1'b1;
    unique case (state)
      rism_pkg::S_IDLE: begin
        in_stall = out_valid && out_stall;
        ctrl.load_in = in_valid && !in_stall;
      end
      rism_pkg::S_RD_T: begin ctrl.rd_req = 1'b1; ctrl.rd_sel = 2'd0; end
      rism_pkg::S_RD_S: begin
        ctrl.rd_req = 1'b1; ctrl.rd_sel = 2'd1; ctrl.cap_t = 1'b1;
      end
      rism_pkg::S_RD_D: begin
        ctrl.rd_req = 1'b1; ctrl.rd_sel = 2'd2; ctrl.cap_s = 1'b1;
      end
      // Deepest operand arrives in the cycle after its read.
      rism_pkg::S_CAP_D:  ctrl.cap_d = 1'b1;
      rism_pkg::S_EXEC:   ctrl.start = 1'b1;
      rism_pkg::S_ITER:   ctrl.step = 1'b1;
      rism_pkg::S_WRITE:  ctrl.write = 1'b1;
      rism_pkg::S_RD_TOP: begin ctrl.rd_req = 1'b1; ctrl.rd_sel = 2'd0; end
      rism_pkg::S_TOP:    ctrl.cap_top = 1'b1;
      rism_pkg::S_OUT:    ctrl.out_load = !(out_valid && out_stall);
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (ctrl.out_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rism_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= (state == rism_pkg::S_OUT && !ctrl.out_load) ? state : state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rpn_integer_stack_machine_unit.sv =====
// Top level of the RPN integer stack machine.
// Usage:
//   Input channel (in_valid/in_stall) carries one token per item: req_type 0
//   pushes number, req_type 1 applies opcode; fresh_start empties the stack first.
//   Output channel (out_valid/out_stall) returns one item per token: top_value,
//   top_valid, depth and status.
//   Pushes and rejected tokens (overflow, underflow, bad opcode) skip the
//   operand fetch. Division by a nonzero divisor iterates over its 32 quotient
//   bits; power with a non-negative exponent takes two multiply phases per
//   exponent bit. The stack lives in one single-port RAM, so the top, second
//   and deepest slots are read one after another, whatever the operator's arity.
//   One item is in flight at a time; the next can be taken the cycle after its
//   result is loaded into the output register, unless that result is stalled.
//   Reset empties the stack and drops any pending result; stack contents need
//   no clearing pass.
//   A stalled result holds in the output register; the input is stalled
//   until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module rpn_integer_stack_machine_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               req_type,
  input  wire logic signed [31:0] number,
  input  wire logic [3:0]         opcode,
  input  wire logic               fresh_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      top_value,
  output logic                    top_valid,
  output logic [6:0]              depth,
  output logic [1:0]              status
);
  rism_pkg::ctrl_t ctrl;
  rism_pkg::stat_t stat;

  // Sequence reads, execution, write-back and report.
  rism_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  // Hold the stack and compute.
  rism_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .req_type(req_type), .number(number), .opcode(opcode),
    .fresh_start(fresh_start), .top_value(top_value), .top_valid(top_valid),
    .depth(depth), .status(status)
  );

  // A result that is valid agrees with its depth.
  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_valid == (depth != 7'd0))) else $error("top_valid mismatch");
  // No new item while a result is stalled.
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("accept while stalled");
  // Depth never exceeds the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (depth <= 7'(STACK_DEPTH))) else $error("depth overrun");
endmodule
`default_nettype wire

// ===== tb/rpn_integer_stack_machine_unit_tb.sv =====
// Self-checking testbench for the RPN integer stack machine.
`timescale 1ns / 1ps
`default_nettype none
module rpn_integer_stack_machine_unit_tb;

  localparam int DEPTH_MAX = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [3:0] OP_BAD_LO = 4'd11;
  localparam logic [3:0] OP_BAD_HI = 4'd15;

  typedef struct {
    logic        req_type;
    logic [31:0] number;
    logic [3:0]  opcode;
    logic        fresh_start;
    logic        wait_drain;  // hold this token until every result is back
  } token_t;

  typedef struct {
    logic [31:0] top_value;
    logic        top_valid;
    logic [6:0]  depth;
    logic [1:0]  status;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic signed [31:0] number = '0;
  logic [3:0] opcode = '0;
  logic fresh_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] top_value;
  logic top_valid;
  logic [6:0] depth;
  logic [1:0] status;

  rpn_integer_stack_machine_unit #(.STACK_DEPTH(DEPTH_MAX)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .number(number), .opcode(opcode), .fresh_start(fresh_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .top_valid(top_valid), .depth(depth), .status(status)
  );

  always #6 clk = ~clk;

  token_t  pending_tokens[$];
  report_t expected_reports[$];
  int      errors = 0;
  int      tokens_sent = 0;
  int      reports_seen = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  int      op_hits[16];
  int      status_hits[4];

  // Shadow stack kept by the predictor.
  logic [31:0] shadow_stack[DEPTH_MAX];
  int          shadow_depth = 0;

  function automatic logic [31:0] quotient_of(logic [31:0] a, logic [31:0] b);
    if (b == 0) return a[31] ? (32'd0 - rism_pkg::INT_MAX) : rism_pkg::INT_MAX;
    // 64-bit signed division keeps INT_MIN / -1 from trapping; truncate back.
    return 32'(longint'($signed(a)) / longint'($signed(b)));
  endfunction

  function automatic logic [31:0] power_of(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1;
    sq = base;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (ex != 0) begin
      if (ex[0]) acc = acc * sq;
      sq = sq * sq;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic int operands_needed(logic [3:0] op);
    if (op == rism_pkg::OP_CHOICE) return 3;
    if (op == rism_pkg::OP_ASSIGN || op == rism_pkg::OP_NEG || op == rism_pkg::OP_NOT)
      return 1;
    return 2;
  endfunction

  // Advance the shadow stack by one token and return the report it should give.
  function automatic report_t predict_report(token_t tk);
    report_t rp;
    logic [31:0] t, s, d, r;
    int n;
    rp.status = rism_pkg::ST_OK;
    if (tk.fresh_start) shadow_depth = 0;
    if (!tk.req_type) begin
      if (shadow_depth >= DEPTH_MAX) rp.status = rism_pkg::ST_OVER;
      else begin
        shadow_stack[shadow_depth] = tk.number;
        shadow_depth++;
      end
    end else if (tk.opcode > rism_pkg::OP_POW) begin
      rp.status = rism_pkg::ST_BADOP;
    end else begin
      n = operands_needed(tk.opcode);
      if (shadow_depth < n) rp.status = rism_pkg::ST_UNDER;
      else begin
        t = shadow_stack[shadow_depth-1];
        s = (n >= 2) ? shadow_stack[shadow_depth-2] : 32'd0;
        d = (n >= 3) ? shadow_stack[shadow_depth-3] : 32'd0;
        case (rism_pkg::opcode_t'(tk.opcode))
          rism_pkg::OP_ADD:    r = s + t;
          rism_pkg::OP_SUB:    r = s - t;
          rism_pkg::OP_MUL:    r = s * t;
          rism_pkg::OP_DIV:    r = quotient_of(s, t);
          rism_pkg::OP_CHOICE: r = (d != 0) ? s : t;
          rism_pkg::OP_ASSIGN: r = t;
          rism_pkg::OP_NEG:    r = 32'd0 - t;
          rism_pkg::OP_NOT:    r = ~t;
          rism_pkg::OP_AND:    r = s & t;
          rism_pkg::OP_OR:     r = s | t;
          default:             r = power_of(s, t);
        endcase
        shadow_depth -= n;
        shadow_stack[shadow_depth] = r;
        shadow_depth++;
      end
    end
    rp.top_value = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : 32'd0;
    rp.top_valid = (shadow_depth > 0);
    rp.depth = 7'(shadow_depth);
    return rp;
  endfunction

  // Mostly short gaps, now and then a long one; some stretches with none.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'(int'($urandom_range(0, 6)) - 3);
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic token_t push_tok(logic [31:0] v, bit fresh = 0);
    token_t tk;
    tk.req_type = 1'b0;
    tk.number = v;
    tk.opcode = 4'($urandom);  // ignored on a push
    tk.fresh_start = fresh;
    tk.wait_drain = 0;
    return tk;
  endfunction

  function automatic token_t op_tok(logic [3:0] op, bit fresh = 0);
    token_t tk;
    tk.req_type = 1'b1;
    tk.number = $urandom;      // ignored on an operator
    tk.opcode = op;
    tk.fresh_start = fresh;
    tk.wait_drain = 0;
    return tk;
  endfunction

  // Driver: present one token at a time, hold it while stalled.
  int  send_gap = 0;
  always @(posedge clk) begin
    token_t tk;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tk.req_type = req_type;
        tk.number = number;
        tk.opcode = opcode;
        tk.fresh_start = fresh_start;
        expected_reports.push_back(predict_report(tk));
        if (tk.req_type) op_hits[tk.opcode]++;
        tokens_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_tokens.size() > 0 && pending_tokens[0].wait_drain &&
                     (expected_reports.size() > 0 || (in_valid && !in_stall))) begin
          // hold off until the block has returned everything
          in_valid <= 1'b0;
        end else if (pending_tokens.size() > 0) begin
          tk = pending_tokens.pop_front();
          req_type <= tk.req_type;
          number <= tk.number;
          opcode <= tk.opcode;
          fresh_start <= tk.fresh_start;
          in_valid <= 1'b1;
          send_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted report with the oldest prediction.
  always @(posedge clk) begin
    report_t ex;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        status_hits[status]++;
        if (expected_reports.size() == 0) begin
          $error("unexpected report: top %0d depth %0d status %0d", top_value, depth, status);
          errors++;
        end else begin
          ex = expected_reports.pop_front();
          if (top_value !== ex.top_value) begin
            $error("top_value: expected %0d, got %0d", $signed(ex.top_value), top_value);
            errors++;
          end
          if (top_valid !== ex.top_valid) begin
            $error("top_valid: expected %0d, got %0d", ex.top_valid, top_valid);
            errors++;
          end
          if (depth !== ex.depth) begin
            $error("depth: expected %0d, got %0d", ex.depth, depth);
            errors++;
          end
          if (status !== ex.status) begin
            $error("status: expected %0d, got %0d", ex.status, status);
            errors++;
          end
        end
      end
      // Stall in runs: mostly none or short, now and then a long one.
      if (stall_left == 0) stall_left = gap_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Build stimulus, release reset, wait for the drain and report.
  initial begin
    token_t tk;
    int sent_target;
    int run_len;
    // Directed: arithmetic corners and error paths.
    pending_tokens.push_back(op_tok(rism_pkg::OP_ADD));       // underflow, empty stack
    pending_tokens.push_back(push_tok(32'h8000_0000));
    pending_tokens.push_back(push_tok(32'hFFFF_FFFF));
    pending_tokens.push_back(op_tok(rism_pkg::OP_DIV));       // INT_MIN / -1 wraps
    pending_tokens.push_back(op_tok(rism_pkg::OP_NEG));       // negate INT_MIN
    pending_tokens.push_back(push_tok(32'd0));
    pending_tokens.push_back(op_tok(rism_pkg::OP_DIV));       // negative / 0
    pending_tokens.push_back(push_tok(32'h7FFF_FFFF, 1));
    pending_tokens.push_back(push_tok(32'd0));
    pending_tokens.push_back(op_tok(rism_pkg::OP_DIV));       // positive / 0
    pending_tokens.push_back(op_tok(OP_BAD_LO));
    pending_tokens.push_back(op_tok(OP_BAD_HI, 1));           // fresh start with error
    pending_tokens.push_back(push_tok(32'hFFFF_FFFF));
    pending_tokens.push_back(push_tok(32'hFFFF_FFFB));
    pending_tokens.push_back(op_tok(rism_pkg::OP_POW));       // -1 to a negative odd power
    pending_tokens.push_back(push_tok(32'd0));
    pending_tokens.push_back(push_tok(32'd0));
    pending_tokens.push_back(op_tok(rism_pkg::OP_POW));       // zero to the zero
    pending_tokens.push_back(push_tok(32'd3));
    pending_tokens.push_back(push_tok(32'd7));
    pending_tokens.push_back(op_tok(rism_pkg::OP_CHOICE));
    pending_tokens.push_back(op_tok(rism_pkg::OP_NOT));
    pending_tokens.push_back(op_tok(rism_pkg::OP_ASSIGN));
    // Fill to the limit, then one more push overflows.
    for (int i = 0; i < DEPTH_MAX + 1; i++)
      pending_tokens.push_back(push_tok(rand_word(), i == 0));
    tk = op_tok(rism_pkg::OP_MUL);
    tk.wait_drain = 1;
    pending_tokens.push_back(tk);

    // Random: mostly well-formed expressions, some noise.
    sent_target = 1550 - 2 * (DEPTH_MAX + 3);
    while (pending_tokens.size() < sent_target) begin
      run_len = $urandom_range(1, 12);
      pending_tokens.push_back(push_tok(rand_word(), $urandom_range(0, 9) == 0));
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(0, 9))
          0: pending_tokens.push_back(op_tok(4'($urandom_range(0, 15)),
                                             $urandom_range(0, 30) == 0));
          1, 2, 3: pending_tokens.push_back(op_tok(4'($urandom_range(0, 10))));
          default: begin
            pending_tokens.push_back(push_tok(rand_word()));
            pending_tokens.push_back(op_tok(4'($urandom_range(0, 10))));
          end
        endcase
      end
      if ($urandom_range(0, 40) == 0) begin
        tk = push_tok(rand_word());
        tk.wait_drain = 1;
        pending_tokens.push_back(tk);
      end
    end
    // After the random part, pile the stack up to the limit again.
    for (int i = 0; i < DEPTH_MAX + 3; i++) pending_tokens.push_back(push_tok(rand_word()));
    for (int i = 0; i < DEPTH_MAX + 3; i++) pending_tokens.push_back(op_tok(rism_pkg::OP_ADD));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tokens.size() == 0 && !in_valid && expected_reports.size() == 0);
    repeat (100) @(posedge clk);
    $display("Run covered %0d tokens and %0d reports.", tokens_sent, reports_seen);
    $display("Statuses seen: ok %0d, underflow %0d, overflow %0d, bad opcode %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
